@@ src/bfa_pkg.sv @@
// bfa_pkg: shared widths, codes and state encoding of the bitmap frame allocator
// no dependencies; used by the channel interfaces and by bitmap_frame_allocator
package bfa_pkg;

	localparam int CFG_W    = 8;   // words_in_use register
	localparam int FRAME_W  = 13;  // frame numbers, run lengths, used count
	localparam int ADDR_W   = 32;  // physical addresses
	localparam int WORD_W   = 32;  // frames per bitmap word
	localparam int BIT_W    = 5;   // bit index inside a bitmap word
	localparam int BYTE_W   = 8;   // bits examined per search cycle
	localparam int STAT_W   = 3;

	localparam logic [CFG_W-1:0]   WORDS_RESET = 8'd128;
	localparam logic [FRAME_W-1:0] COUNT_MAX   = 13'h1FFF;
	localparam logic [WORD_W-1:0]  ALL_ONES    = 32'hFFFF_FFFF;

	typedef enum logic {
		CMD_ALLOC = 1'b0,
		CMD_FREE  = 1'b1
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		ST_ALLOC    = 3'd0,
		ST_NO_SPACE = 3'd1,
		ST_NO_RUN   = 3'd2,
		ST_FREED    = 3'd3,
		ST_RANGE    = 3'd4
	} status_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_CHECK,
		S_SRCH,
		S_MARK,
		S_DIV,
		S_QUO,
		S_FCHK,
		S_FWR,
		S_DONE
	} state_t;

endpackage

@@ src/bfa_cfg_if.sv @@
// bfa_cfg_if: configuration write channel (words_in_use)
// depends on bfa_pkg
interface bfa_cfg_if
	import bfa_pkg::*;
();
	logic             valid;
	logic             ready;
	logic [CFG_W-1:0] data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ src/bfa_cmd_if.sv @@
// bfa_cmd_if: command channel, one allocate or free word per handshake
// depends on bfa_pkg
interface bfa_cmd_if
	import bfa_pkg::*;
();
	logic               valid;
	logic               ready;
	logic               cmd;
	logic [FRAME_W-1:0] run_length;
	logic [ADDR_W-1:0]  free_addr;

	modport source (output valid, output cmd, output run_length, output free_addr, input ready);
	modport sink (input valid, input cmd, input run_length, input free_addr, output ready);
endinterface

@@ src/bfa_res_if.sv @@
// bfa_res_if: result channel, one word per command
// depends on bfa_pkg
interface bfa_res_if
	import bfa_pkg::*;
();
	logic               valid;
	logic               ready;
	logic [STAT_W-1:0]  status;
	logic [ADDR_W-1:0]  alloc_addr;
	logic [FRAME_W-1:0] used_frames;

	modport source (output valid, output status, output alloc_addr, output used_frames,
		input ready);
	modport sink (input valid, input status, input alloc_addr, input used_frames,
		output ready);
endinterface

@@ src/bitmap_frame_allocator.sv @@
// bitmap_frame_allocator: first-fit frame allocator over a used-frame bitmap memory
// depends on bfa_pkg, bfa_cfg_if, bfa_cmd_if, bfa_res_if
//
// channel | dir | word
// --------+-----+----------------------------------------------
// cfg     | in  | data: words_in_use
// req     | in  | cmd, run_length, free_addr
// rsp     | out | status, alloc_addr, used_frames
//
// free: reciprocal multiply for the divide by BLOCK_BYTES, a read, then a write if in range
// allocate: a check state, then a byte-at-a-time search (one byte per cycle through
//   the memory read register), then a write to each word the run spans, then the result
// after reset a clearing pass zeroes all MAX_WORDS bitmap words; req.ready stays low
// one command at a time; the result register lets the next command start while rsp stalls
// cfg is always ready; write it only while no command is in flight, not enforced here
module bitmap_frame_allocator
	import bfa_pkg::*;
#(
	parameter int MAX_WORDS   = 128,
	parameter int BLOCK_BYTES = 4096
) (
	input logic       clk,
	input logic       arst_n,
	bfa_cfg_if.sink   cfg,
	bfa_cmd_if.sink   req,
	bfa_res_if.source rsp
);

	localparam int WA     = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
	localparam int MW_CAP = (MAX_WORDS > 255) ? 255 : MAX_WORDS;
	localparam int BW     = $clog2(BLOCK_BYTES + 1);
	localparam int PW     = FRAME_W + BW;
	localparam int PRODW  = 2 * ADDR_W;
	localparam int QSH    = ADDR_W + $clog2(BLOCK_BYTES);

	localparam logic [CFG_W-1:0] MW_CAP_C = CFG_W'(MW_CAP);
	localparam logic [BW-1:0]    BLOCK_C  = BW'(BLOCK_BYTES);
	localparam logic [WA-1:0]    CLR_LAST = WA'(MAX_WORDS - 1);
	localparam logic [BIT_W-1:0] LAST_BIT = BIT_W'(WORD_W - 1);

	// scaled reciprocal of BLOCK_BYTES, floor plus one; fits in ADDR_W+1 bits
	localparam logic [PRODW-1:0]  RECIP    =
		((PRODW'(1) << QSH) / PRODW'(BLOCK_BYTES)) + PRODW'(1);
	localparam logic [ADDR_W-1:0] RECIP_LO = RECIP[ADDR_W-1:0];
	localparam logic              RECIP_HI = RECIP[ADDR_W];

	// control state
	state_t             state_q, state_d;
	logic [CFG_W-1:0]   words_q;
	logic [FRAME_W-1:0] used_q;
	logic               out_valid_q;
	logic               mv_s1;
	logic [WA-1:0]      clr_q;

	// command and datapath registers
	logic [FRAME_W-1:0] n_q;
	status_t            st_q;
	logic [ADDR_W-1:0]  quo_q;
	logic [PRODW-1:0]   qprod_q;
	logic [CFG_W-1:0]   w_q;
	logic [1:0]         byte_q;
	logic [FRAME_W-1:0] run_q;
	logic [FRAME_W-1:0] start_q, end_q;
	logic [CFG_W-1:0]   rd_q;
	logic [CFG_W-1:0]   mw_s1;
	logic [ADDR_W-1:0]  prod_q;
	logic [STAT_W-1:0]  out_status_q;
	logic [ADDR_W-1:0]  out_addr_q;
	logic [FRAME_W-1:0] out_used_q;

	// bitmap memory
	logic [WORD_W-1:0] mem [MAX_WORDS];
	logic [WORD_W-1:0] mem_rdata_q;
	logic [WA-1:0]     mem_raddr, mem_waddr;
	logic [WORD_W-1:0] mem_wdata;
	logic              mem_we;
	logic [CFG_W-1:0]  raddr_w;

	// combinational
	logic [CFG_W-1:0]   mw;
	logic [FRAME_W-1:0] managed, free_frames, used_nx;
	logic [FRAME_W:0]   used_sum;
	logic               out_free, in_range, last_word, mark_issue;
	logic [PRODW:0]     qsum;
	logic [BYTE_W-1:0]  srch_byte;
	logic [FRAME_W-1:0] run_nx, cnt;
	logic               hit;
	logic [2:0]         hit_bit;
	logic [FRAME_W-1:0] hit_frame, hit_start;
	logic [BIT_W-1:0]   mask_lo, mask_hi;
	logic [WORD_W-1:0]  mark_mask;
	logic [PW-1:0]      prod_full;

	// managed range and free count
	assign mw          = (words_q > MW_CAP_C) ? MW_CAP_C : words_q;
	assign managed     = {mw, BIT_W'(0)};
	assign free_frames = (used_q > managed) ? '0 : managed - used_q;
	assign in_range    = quo_q < ADDR_W'(managed);
	assign last_word   = (w_q == mw - 8'd1);
	assign out_free    = !out_valid_q || rsp.ready;

	// handshakes
	assign req.ready       = (state_q == S_IDLE);
	assign cfg.ready       = 1'b1;
	assign rsp.valid       = out_valid_q;
	assign rsp.status      = out_status_q;
	assign rsp.alloc_addr  = out_addr_q;
	assign rsp.used_frames = out_used_q;

	// second half of the reciprocal multiply: add the top bit of the reciprocal
	assign qsum = {1'b0, qprod_q} + (RECIP_HI ? {1'b0, quo_q, ADDR_W'(0)} : '0);

	// run counting over one byte of the current bitmap word
	always_comb begin
		srch_byte = mem_rdata_q[{byte_q, 3'b000} +: BYTE_W];
		cnt       = run_q;
		hit       = 1'b0;
		hit_bit   = '0;
		for (int i = 0; i < BYTE_W; i++) begin
			if (srch_byte[i]) begin
				cnt = '0;
			end else begin
				cnt = cnt + 1'b1;
			end
			if (!hit && cnt == n_q) begin
				hit     = 1'b1;
				hit_bit = 3'(i);
			end
		end
		run_nx = cnt;
	end

	assign hit_frame = {w_q, byte_q, hit_bit};
	assign hit_start = hit_frame - n_q + 1'b1;

	// bits of the run inside the word being marked
	assign mask_lo   = (mw_s1 == start_q[FRAME_W-1:BIT_W]) ? start_q[BIT_W-1:0] : '0;
	assign mask_hi   = (mw_s1 == end_q[FRAME_W-1:BIT_W]) ? end_q[BIT_W-1:0] : LAST_BIT;
	assign mark_mask = (ALL_ONES << mask_lo) & (ALL_ONES >> (LAST_BIT - mask_hi));

	assign prod_full = PW'(start_q) * PW'(BLOCK_C);

	// used count after the command
	assign used_sum = {1'b0, used_q} + {1'b0, n_q};
	always_comb begin
		unique case (st_q)
			ST_ALLOC: used_nx = used_sum[FRAME_W] ? COUNT_MAX : used_sum[FRAME_W-1:0];
			ST_FREED: used_nx = (used_q == '0) ? '0 : used_q - 1'b1;
			default:  used_nx = used_q;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and memory port control
	always_comb begin
		state_d    = state_q;
		mem_we     = 1'b0;
		mem_waddr  = WA'(mw_s1);
		mem_wdata  = mem_rdata_q | mark_mask;
		raddr_w    = w_q;
		mark_issue = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = '0;
				if (clr_q == CLR_LAST) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (req.valid) begin
					state_d = (req.cmd == CMD_FREE) ? S_DIV : S_CHECK;
				end
			end
			S_CHECK: begin
				raddr_w = '0;
				if (free_frames < n_q || n_q == '0) begin
					state_d = S_DONE;
				end else begin
					state_d = S_SRCH;
				end
			end
			S_SRCH: begin
				if (byte_q == 2'd3) begin
					raddr_w = w_q + 8'd1;
				end
				if (hit) begin
					state_d = S_MARK;
				end else if (byte_q == 2'd3 && last_word) begin
					state_d = S_DONE;
				end
			end
			S_MARK: begin
				raddr_w    = rd_q;
				mark_issue = (rd_q <= end_q[FRAME_W-1:BIT_W]);
				if (mv_s1) begin
					mem_we = 1'b1;
					if (mw_s1 == end_q[FRAME_W-1:BIT_W]) begin
						state_d = S_DONE;
					end
				end
			end
			S_DIV: begin
				state_d = S_QUO;
			end
			S_QUO: begin
				state_d = S_FCHK;
			end
			S_FCHK: begin
				raddr_w = quo_q[FRAME_W-1:BIT_W];
				state_d = in_range ? S_FWR : S_DONE;
			end
			S_FWR: begin
				mem_we    = 1'b1;
				mem_waddr = WA'(quo_q[FRAME_W-1:BIT_W]);
				mem_wdata = mem_rdata_q & ~(WORD_W'(1) << quo_q[BIT_W-1:0]);
				state_d   = S_DONE;
			end
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign mem_raddr = WA'(raddr_w);

	// bitmap memory, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		mem_rdata_q <= mem[mem_raddr];
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			words_q     <= WORDS_RESET;
			used_q      <= '0;
			out_valid_q <= 1'b0;
			mv_s1       <= 1'b0;
			clr_q       <= '0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				words_q <= cfg.data;
			end
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (state_q == S_SRCH) begin
				mv_s1 <= 1'b0;
			end else if (state_q == S_MARK) begin
				mv_s1 <= mark_issue;
			end
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
				used_q      <= used_nx;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				n_q   <= req.run_length;
				quo_q <= req.free_addr;
			end
			S_CHECK: begin
				w_q    <= '0;
				byte_q <= '0;
				run_q  <= '0;
				st_q   <= (free_frames < n_q) ? ST_NO_SPACE : ST_NO_RUN;
			end
			S_SRCH: begin
				run_q  <= run_nx;
				byte_q <= byte_q + 2'd1;
				if (hit) begin
					start_q <= hit_start;
					end_q   <= hit_frame;
					rd_q    <= hit_start[FRAME_W-1:BIT_W];
					st_q    <= ST_ALLOC;
				end else if (byte_q == 2'd3) begin
					w_q <= w_q + 8'd1;
				end
			end
			S_MARK: begin
				prod_q <= ADDR_W'(prod_full);
				mw_s1  <= rd_q;
				if (mark_issue) begin
					rd_q <= rd_q + 8'd1;
				end
			end
			// address times the low word of the reciprocal
			S_DIV: begin
				qprod_q <= PRODW'(quo_q) * PRODW'(RECIP_LO);
			end
			// frame number is the scaled product
			S_QUO: begin
				quo_q <= ADDR_W'(qsum >> QSH);
			end
			S_FCHK: begin
				st_q <= in_range ? ST_FREED : ST_RANGE;
			end
			S_DONE: begin
				if (out_free) begin
					out_status_q <= st_q;
					out_addr_q   <= (st_q == ST_ALLOC) ? prod_q : '0;
					out_used_q   <= used_nx;
				end
			end
			default: begin
			end
		endcase
	end

	// no bitmap write while a new command can be taken
	a_idle_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !mem_we)
		else $error("bitmap written while idle");

	// failed or free commands report a zero address
	a_zero_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_status_q != ST_ALLOC) |-> (out_addr_q == '0))
		else $error("nonzero address on a non-allocate result");

	// marking writes only words that the found run covers
	a_mark_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MARK && mv_s1) |->
		(mw_s1 >= start_q[FRAME_W-1:BIT_W] && mw_s1 <= end_q[FRAME_W-1:BIT_W]))
		else $error("mark write outside the run");

	// the search word index never passes the managed words
	a_srch_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SRCH) |-> (w_q < mw))
		else $error("search beyond managed words");

	// a completed free shows up as the next result
	a_free_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && out_free && st_q == ST_FREED) |=>
		(out_valid_q && out_status_q == ST_FREED))
		else $error("free result lost");

endmodule

@@ verif/tb.sv @@
// tb: self-checking testbench of bitmap_frame_allocator, allocate and free words with a
// predictor of the frame bitmap, random handshake gaps and a words_in_use sweep
// depends on bfa_pkg, bfa_cfg_if, bfa_cmd_if, bfa_res_if and bitmap_frame_allocator
module tb;
	import bfa_pkg::*;

	localparam int MAP_WORDS      = 128;
	localparam int FRAME_BYTES    = 4096;
	localparam int HOLDOFF_CYCLES = 400;
	localparam int DRAIN_CYCLES   = 700;
	localparam int CYCLE_LIMIT    = 2_000_000;
	localparam int MAX_REPORTS    = 50;

	typedef struct {
		cmd_t               cmd;
		logic [FRAME_W-1:0] len;
		logic [ADDR_W-1:0]  addr;
	} frame_cmd_t;

	typedef struct {
		status_t            status;
		logic [ADDR_W-1:0]  addr;
		logic [FRAME_W-1:0] used;
	} frame_outcome_t;

	logic clk;
	logic arst_n;

	bfa_cfg_if cfg();
	bfa_cmd_if req();
	bfa_res_if rsp();

	bitmap_frame_allocator #(
		.MAX_WORDS(MAP_WORDS),
		.BLOCK_BYTES(FRAME_BYTES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.req(req),
		.rsp(rsp)
	);

	// predicted allocator state
	logic [WORD_W-1:0] frame_map [MAP_WORDS];
	int                used_frames_model;
	logic [CFG_W-1:0]  words_cfg;

	frame_cmd_t     cmd_backlog [$];
	frame_outcome_t outcome_queue [$];

	int mismatches;
	int cycle_count;
	int burst_left;
	int gap_left;
	int holdoff_left;
	bit holdoff_armed;
	int pattern_age;
	logic [15:0] stall_pattern;

	// clock and reset
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		cfg.valid = 1'b0;
		cfg.data = '0;
		req.valid = 1'b0;
		req.cmd = CMD_ALLOC;
		req.run_length = '0;
		req.free_addr = '0;
		rsp.ready = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
	end

	always @(posedge clk) cycle_count <= cycle_count + 1;

	initial begin
		wait (cycle_count == CYCLE_LIMIT);
		$display("tb failed");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("mismatch at cycle %0d: %s", cycle_count, msg);
	endtask

	function automatic int managed_frames();
		return ((words_cfg > MAP_WORDS) ? MAP_WORDS : int'(words_cfg)) * WORD_W;
	endfunction

	// first-fit allocate or single-frame free on the predicted bitmap
	function automatic frame_outcome_t allocate_or_free(input frame_cmd_t c);
		frame_outcome_t o;
		int managed, free_cnt, n, run, start, w, b, f;
		bit found;
		logic [ADDR_W-1:0] frame_no;
		managed = managed_frames();
		o.addr = '0;
		if (c.cmd == CMD_ALLOC) begin
			n = int'(c.len);
			free_cnt = (used_frames_model > managed) ? 0 : managed - used_frames_model;
			found = 1'b0;
			run = 0;
			start = 0;
			if (free_cnt < n) begin
				o.status = ST_NO_SPACE;
			end else begin
				if (n > 0) begin
					for (w = 0; w < managed / WORD_W && !found; w++) begin
						// a full word is skipped and breaks the run
						if (frame_map[w] == ALL_ONES) begin
							run = 0;
						end else begin
							for (b = 0; b < WORD_W && !found; b++) begin
								if (!frame_map[w][b]) begin
									if (run == 0)
										start = w * WORD_W + b;
									run++;
									if (run == n)
										found = 1'b1;
								end else begin
									run = 0;
								end
							end
						end
					end
				end
				if (!found) begin
					o.status = ST_NO_RUN;
				end else begin
					for (f = start; f < start + n; f++)
						frame_map[f / WORD_W][f % WORD_W] = 1'b1;
					used_frames_model = used_frames_model + n;
					if (used_frames_model > int'(COUNT_MAX))
						used_frames_model = int'(COUNT_MAX);
					o.addr = ADDR_W'(start) * ADDR_W'(FRAME_BYTES);
					o.status = ST_ALLOC;
				end
			end
		end else begin
			frame_no = c.addr / ADDR_W'(FRAME_BYTES);
			if (frame_no >= ADDR_W'(managed)) begin
				o.status = ST_RANGE;
			end else begin
				// freeing a free frame still drops the count
				frame_map[frame_no / WORD_W][frame_no % WORD_W] = 1'b0;
				if (used_frames_model > 0)
					used_frames_model--;
				o.status = ST_FREED;
			end
		end
		o.used = FRAME_W'(used_frames_model);
		return o;
	endfunction

	// command driver: bursts of words from the backlog with random gaps
	always @(posedge clk) begin : cmd_driver
		frame_cmd_t next_cmd;
		frame_cmd_t offered_cmd;
		logic       offering;
		if (!arst_n) begin
			req.valid <= 1'b0;
		end else begin
			offering = req.valid;
			if (req.valid && req.ready) begin
				outcome_queue.push_back(allocate_or_free(offered_cmd));
				offering = 1'b0;
				if (burst_left > 0)
					burst_left--;
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 16);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 24);
				end
			end
			if (!offering) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (cmd_backlog.size() != 0) begin
					next_cmd = cmd_backlog.pop_front();
					offered_cmd = next_cmd;
					req.cmd <= next_cmd.cmd;
					req.run_length <= next_cmd.len;
					req.free_addr <= next_cmd.addr;
					offering = 1'b1;
				end
			end
			req.valid <= offering;
		end
	end

	// result ready: own stall pattern, plus a long hold-off when armed
	always @(posedge clk) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
		end else begin
			if (holdoff_armed) begin
				holdoff_armed = 1'b0;
				holdoff_left = HOLDOFF_CYCLES;
			end
			if (holdoff_left > 0) begin
				holdoff_left--;
				rsp.ready <= 1'b0;
			end else begin
				if (pattern_age == 0) begin
					stall_pattern = ($urandom_range(0, 3) == 0) ? '1 : 16'($urandom | $urandom);
					pattern_age = 48;
				end
				pattern_age--;
				rsp.ready <= stall_pattern[pattern_age % 16];
			end
		end
	end

	// result monitor: compare each word with the oldest prediction
	always @(posedge clk) begin : result_monitor
		frame_outcome_t want;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (outcome_queue.size() == 0) begin
				report_mismatch($sformatf("result with none expected: status %0d addr %h used %0d",
					rsp.status, rsp.alloc_addr, rsp.used_frames));
			end else begin
				want = outcome_queue.pop_front();
				if (rsp.status !== want.status)
					report_mismatch($sformatf("status %0d, expected %0d", rsp.status, want.status));
				if (rsp.alloc_addr !== want.addr)
					report_mismatch($sformatf("alloc_addr %h, expected %h", rsp.alloc_addr,
						want.addr));
				if (rsp.used_frames !== want.used)
					report_mismatch($sformatf("used_frames %0d, expected %0d", rsp.used_frames,
						want.used));
			end
		end
	end

	task automatic push_alloc(input int len);
		cmd_backlog.push_back('{cmd: CMD_ALLOC, len: FRAME_W'(len), addr: ADDR_W'($urandom)});
	endtask

	task automatic push_free(input logic [ADDR_W-1:0] addr);
		cmd_backlog.push_back('{cmd: CMD_FREE, len: FRAME_W'($urandom), addr: addr});
	endtask

	// mostly short runs and frees inside the managed frames, some noise
	task automatic push_random(input int count);
		int managed, r, i;
		managed = managed_frames();
		for (i = 0; i < count; i++) begin
			r = $urandom_range(0, 99);
			if (r < 36)
				push_alloc($urandom_range(1, 3));
			else if (r < 44)
				push_alloc($urandom_range(4, 40));
			else if (r < 47)
				push_alloc((managed > 0) ? $urandom_range(1, managed) : 1);
			else if (r < 49)
				push_alloc($urandom);
			else if (r < 92 && managed > 0)
				push_free(ADDR_W'($urandom_range(0, managed - 1)) * ADDR_W'(FRAME_BYTES)
					+ ADDR_W'($urandom_range(0, FRAME_BYTES - 1)));
			else if (r < 97)
				push_free($urandom);
			else
				push_alloc(0);
		end
	endtask

	task automatic wait_until_idle();
		do @(negedge clk);
		while (cmd_backlog.size() != 0 || outcome_queue.size() != 0 || req.valid);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_words_in_use(input logic [CFG_W-1:0] value);
		@(posedge clk);
		cfg.valid <= 1'b1;
		cfg.data <= value;
		do @(posedge clk);
		while (!(cfg.valid && cfg.ready));
		words_cfg = value;
		cfg.valid <= 1'b0;
	endtask

	// stimulus and end of run
	initial begin
		for (int i = 0; i < MAP_WORDS; i++)
			frame_map[i] = '0;
		used_frames_model = 0;
		words_cfg = WORDS_RESET;
		mismatches = 0;
		cycle_count = 0;
		burst_left = 0;
		gap_left = 0;
		holdoff_left = 0;
		holdoff_armed = 1'b0;
		pattern_age = 0;
		stall_pattern = '1;
		wait (arst_n === 1'b1);

		// directed: whole map, zero and oversize runs, range limits, holes
		push_alloc(1);
		push_alloc(0);
		push_alloc(4096);
		push_alloc(8191);
		push_free(32'h0000_0000);
		push_free(32'h0000_0000);
		push_free(32'hFFFF_FFFF);
		push_free(32'h0100_0000);
		push_alloc(4096);
		push_alloc(1);
		push_free(32'h00FF_FFFF);
		push_free(32'h0006_4ABC);
		push_alloc(2);
		push_free(32'h0001_F000);
		push_free(32'h0004_0000);
		push_alloc(3);
		push_alloc(1);
		push_free(32'h0004_0FFF);
		push_free(32'h0004_1000);
		push_alloc(2);
		push_alloc(1);
		push_alloc(1);
		wait_until_idle();

		// nothing managed
		write_words_in_use(8'd0);
		push_alloc(0);
		push_alloc(1);
		push_alloc(4096);
		push_free(32'h0000_0000);
		wait_until_idle();

		// register beyond the store
		write_words_in_use(8'd255);
		push_random(100);
		wait_until_idle();

		// shrunk map with a long result stall in the middle
		write_words_in_use(8'd2);
		push_random(60);
		repeat (20) @(negedge clk);
		holdoff_armed = 1'b1;
		push_random(90);
		wait_until_idle();

		write_words_in_use(8'd1);
		push_random(100);
		wait_until_idle();

		write_words_in_use(8'd8);
		push_random(150);
		wait_until_idle();

		write_words_in_use(8'd128);
		push_random(100);
		wait_until_idle();

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && outcome_queue.size() == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule
